### rtl/core/matb_pkg.sv
`default_nettype none

package matb_pkg;

   localparam int VERTEX_W            = 12;
   localparam int SLOT_FIELD_W        = 5;
   localparam int SLOT_BITS           = VERTEX_W + 1;
   localparam int COUNT_W             = 3;
   localparam int INSERTS_PER_TRI     = 6;
   localparam int QUEUE_DEPTH         = 4;
   localparam int DEF_MAX_NEIGHBOURS  = 32;
   localparam int DEF_VERTEX_CAPACITY = 4096;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_INSERT_LAST,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_kind_type;

   typedef enum logic {
      BK_CLEAR,
      BK_RUN
   } back_state_type;

   typedef logic [SLOT_BITS-1:0] slot_type;

   typedef struct packed {
      action_type              action;
      logic [VERTEX_W-1:0]     vertex_a;
      logic [VERTEX_W-1:0]     vertex_b;
      logic [VERTEX_W-1:0]     vertex_c;
      logic [VERTEX_W-1:0]     query_vertex;
      logic [SLOT_FIELD_W-1:0] query_slot;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] neighbour_vertex;
      logic                neighbour_present;
      logic [COUNT_W-1:0]  edges_added;
      logic [COUNT_W-1:0]  edges_dropped;
   } rsp_type;

   // one unit of back-end work
   typedef struct packed {
      op_kind_type             kind;
      logic                    skip;
      logic [VERTEX_W-1:0]     owner;
      logic [VERTEX_W-1:0]     value;
      logic [SLOT_FIELD_W-1:0] slot;
   } op_type;

   typedef struct packed {
      logic   full;
      logic   empty;
      op_type head;
   } queue_status_type;

endpackage

`default_nettype wire

### rtl/core/mesh_adjacency_table_builder.sv
// Channel   Ports                       Transfer
// input     start, busy, req_data       rising edge with start high and busy low
// result    rsp_valid, rsp_data         one cycle strobe, always taken
//
// An add item turns into six row read-modify-writes, one per cycle through the
// single table write port unless a sweep holds them up; read, clear and unused
// actions take one queue slot. A result strobes once the item's last op has
// passed the queue entry and the stage-one and result registers, later behind
// ops held up by a sweep. A clear, and reset, sweeps the table one row a cycle
// while items wait in the queue. Results have no backpressure; busy only
// reflects the front end and the queue being full.
`default_nettype none

module mesh_adjacency_table_builder
   import matb_pkg::*;
#(
   parameter int MAX_NEIGHBOURS  = DEF_MAX_NEIGHBOURS,
   parameter int VERTEX_CAPACITY = DEF_VERTEX_CAPACITY
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   op_type           q_op;

   matb_front #(
      .MAX_NEIGHBOURS  (MAX_NEIGHBOURS),
      .VERTEX_CAPACITY (VERTEX_CAPACITY)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .q_status (q_status),
      .q_push   (q_push),
      .q_op     (q_op)
   );

   matb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_op),
      .pop     (q_pop),
      .status  (q_status)
   );

   matb_back #(
      .MAX_NEIGHBOURS  (MAX_NEIGHBOURS),
      .VERTEX_CAPACITY (VERTEX_CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### rtl/core/matb_front.sv
`default_nettype none

module matb_front
   import matb_pkg::*;
#(
   parameter int MAX_NEIGHBOURS  = DEF_MAX_NEIGHBOURS,
   parameter int VERTEX_CAPACITY = DEF_VERTEX_CAPACITY
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire req_type          req_data,
   input  wire queue_status_type q_status,
   output logic                  q_push,
   output op_type                q_op
);

   localparam int CMP_W = 18;
   localparam int IDX_W = 3;

   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   req_type           item_ff, item_in;

   logic              last;
   logic              accept;
   logic [VERTEX_W-1:0] owner;
   logic [VERTEX_W-1:0] value;

   always_comb begin
      owner = item_ff.vertex_a;
      value = item_ff.vertex_b;
      case (idx_ff)
         3'd0: begin
            owner = item_ff.vertex_a;
            value = item_ff.vertex_b;
         end
         3'd1: begin
            owner = item_ff.vertex_b;
            value = item_ff.vertex_a;
         end
         3'd2: begin
            owner = item_ff.vertex_a;
            value = item_ff.vertex_c;
         end
         3'd3: begin
            owner = item_ff.vertex_c;
            value = item_ff.vertex_a;
         end
         3'd4: begin
            owner = item_ff.vertex_b;
            value = item_ff.vertex_c;
         end
         default: begin
            owner = item_ff.vertex_c;
            value = item_ff.vertex_b;
         end
      endcase

      q_op       = '0;
      q_op.owner = owner;
      q_op.value = value;
      last       = 1'b1;
      case (item_ff.action)
         ACT_ADD: begin
            last       = (idx_ff == IDX_W'(INSERTS_PER_TRI - 1));
            q_op.kind  = last ? OP_INSERT_LAST : OP_INSERT;
            q_op.skip  = !(CMP_W'(owner) < CMP_W'(VERTEX_CAPACITY));
         end
         ACT_READ: begin
            q_op.kind  = OP_READ;
            q_op.owner = item_ff.query_vertex;
            q_op.slot  = item_ff.query_slot;
            q_op.skip  = !(CMP_W'(item_ff.query_vertex) < CMP_W'(VERTEX_CAPACITY)) ||
                         !(CMP_W'(item_ff.query_slot) < CMP_W'(MAX_NEIGHBOURS));
         end
         ACT_CLEAR: begin
            q_op.kind  = OP_CLEAR;
         end
         default: begin
            q_op.kind  = OP_NOP;
         end
      endcase

      q_push = pend_valid_ff && !q_status.full;
      // free again in the cycle the item's final op goes into the queue
      busy   = pend_valid_ff && !(q_push && last);
      accept = start && !busy;

      pend_valid_in = pend_valid_ff;
      idx_in        = idx_ff;
      item_in       = item_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
         idx_in        = '0;
         item_in       = req_data;
      end else if (q_push) begin
         if (last) begin
            pend_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         idx_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         idx_ff        <= idx_in;
      end
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

### rtl/core/matb_queue.sv
`default_nettype none

module matb_queue
   import matb_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire op_type    push_op,
   input  wire logic      pop,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   op_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   always_comb begin
      status.full  = (count_ff == (PTR_W + 1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      status.head  = entry_ff[rd_ptr_ff];

      do_push = push && !status.full;
      do_pop  = pop && !status.empty;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

### rtl/core/matb_back.sv
`default_nettype none

module matb_back
   import matb_pkg::*;
#(
   parameter int MAX_NEIGHBOURS  = DEF_MAX_NEIGHBOURS,
   parameter int VERTEX_CAPACITY = DEF_VERTEX_CAPACITY
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output rsp_type               rsp_data
);

   localparam int ROW_W  = (VERTEX_CAPACITY > 1) ? $clog2(VERTEX_CAPACITY) : 1;
   localparam int SLOT_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

   typedef slot_type [MAX_NEIGHBOURS-1:0] row_type;

   row_type         table_mem_ff [VERTEX_CAPACITY];

   back_state_type  state_ff, state_in;
   logic [ROW_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic            clr_rsp_ff, clr_rsp_in;
   logic            s1_valid_ff, s1_valid_in;
   op_type          s1_op_ff, s1_op_in;
   row_type         rd_row_ff;
   logic            fwd_valid_ff, fwd_valid_in;
   logic [ROW_W-1:0] fwd_addr_ff;
   row_type         fwd_row_ff;
   logic [COUNT_W-1:0] acc_add_ff, acc_add_in;
   logic [COUNT_W-1:0] acc_drop_ff, acc_drop_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic [ROW_W-1:0] rd_addr;
   logic [ROW_W-1:0] s1_addr;
   row_type         cur_row;
   row_type         new_row;
   logic [MAX_NEIGHBOURS-1:0] slot_valid;
   logic [MAX_NEIGHBOURS-1:0] slot_match;
   logic [MAX_NEIGHBOURS-1:0] first_empty;
   logic            is_ins;
   logic            ins_add;
   logic            ins_drop;
   logic [COUNT_W-1:0] tot_add;
   logic [COUNT_W-1:0] tot_drop;
   slot_type        rd_entry;
   logic            mem_we;
   logic [ROW_W-1:0] mem_waddr;
   row_type         mem_wdata;

   always_comb begin
      rd_addr = ROW_W'(q_status.head.owner);
      s1_addr = ROW_W'(s1_op_ff.owner);

      // row written in the previous cycle is not yet visible to this read
      cur_row = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_row_ff : rd_row_ff;

      // slots fill as a prefix, so the first empty slot is slot 0 or follows a valid one
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         slot_valid[i] = cur_row[i][SLOT_BITS-1];
         slot_match[i] = slot_valid[i] && (cur_row[i][VERTEX_W-1:0] == s1_op_ff.value);
      end
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         if (i == 0) begin
            first_empty[i] = !slot_valid[i];
         end else begin
            first_empty[i] = !slot_valid[i] && slot_valid[i-1];
         end
         new_row[i] = first_empty[i] ? {1'b1, s1_op_ff.value} : cur_row[i];
      end

      is_ins   = s1_valid_ff && !s1_op_ff.skip &&
                 ((s1_op_ff.kind == OP_INSERT) || (s1_op_ff.kind == OP_INSERT_LAST));
      ins_add  = is_ins && !(|slot_match) && !(&slot_valid);
      ins_drop = is_ins && !(|slot_match) && (&slot_valid);
      tot_add  = acc_add_ff + COUNT_W'(ins_add);
      tot_drop = acc_drop_ff + COUNT_W'(ins_drop);

      rd_entry = cur_row[SLOT_W'(s1_op_ff.slot)];

      if (state_ff == BK_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = ins_add;
         mem_waddr = s1_addr;
         mem_wdata = new_row;
      end
      fwd_valid_in = (state_ff == BK_RUN) && ins_add;

      acc_add_in   = acc_add_ff;
      acc_drop_in  = acc_drop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      if (s1_valid_ff) begin
         case (s1_op_ff.kind)
            OP_INSERT: begin
               acc_add_in  = tot_add;
               acc_drop_in = tot_drop;
            end
            OP_INSERT_LAST: begin
               rsp_valid_in         = 1'b1;
               rsp_in.edges_added   = tot_add;
               rsp_in.edges_dropped = tot_drop;
               acc_add_in           = '0;
               acc_drop_in          = '0;
            end
            OP_READ: begin
               rsp_valid_in = 1'b1;
               if (!s1_op_ff.skip && rd_entry[SLOT_BITS-1]) begin
                  rsp_in.neighbour_present = 1'b1;
                  rsp_in.neighbour_vertex  = rd_entry[VERTEX_W-1:0];
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
            end
         endcase
      end

      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      clr_rsp_in  = clr_rsp_ff;
      s1_valid_in = 1'b0;
      s1_op_in    = s1_op_ff;
      q_pop       = 1'b0;
      case (state_ff)
         BK_RUN: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               if (q_status.head.kind == OP_CLEAR) begin
                  state_in   = BK_CLEAR;
                  clr_cnt_in = '0;
                  clr_rsp_in = 1'b1;
               end else begin
                  s1_valid_in = 1'b1;
                  s1_op_in    = q_status.head;
               end
            end
         end
         default: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ROW_W'(VERTEX_CAPACITY - 1)) begin
               state_in   = BK_RUN;
               clr_rsp_in = 1'b0;
               if (clr_rsp_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
               end
            end
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_row_ff <= table_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         acc_add_ff   <= '0;
         acc_drop_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         acc_add_ff   <= acc_add_in;
         acc_drop_ff  <= acc_drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_op_ff    <= s1_op_in;
      fwd_addr_ff <= s1_addr;
      fwd_row_ff  <= new_row;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire
